[rtl/galr_pkg.sv]
package galr_pkg;

  localparam int IDX_W   = 6;
  localparam int DIM_W   = 7;
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 15;
  localparam int Q_SHIFT = 8;

  localparam logic [DIM_W-1:0] DIM_CAP = 7'd64;

  typedef enum logic [2:0] {
    OP_WEIGHT  = 3'd0,
    OP_BIAS    = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_ACCUM   = 3'd3,
    OP_COMPUTE = 3'd4
  } op_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic a_ok;
  } mac_ctl_t;

endpackage

[rtl/galr_ram.sv]
module galr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/galr_mac.sv]
module galr_mac #(
  parameter int FEATURE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  galr_pkg::mac_ctl_t                  ctl,
  input  logic signed [galr_pkg::VAL_W-1:0]   w_data,
  input  logic signed [FEATURE_WIDTH-1:0]     a_data,
  input  logic signed [galr_pkg::VAL_W-1:0]   b_data,
  input  logic                                take,
  output logic                                done,
  output logic [galr_pkg::OUT_W-1:0]          res
);

  localparam int PROD_W = galr_pkg::VAL_W + FEATURE_WIDTH;
  localparam int ACC_W  = FEATURE_WIDTH + 24;
  localparam int TOP_B  = galr_pkg::OUT_W + galr_pkg::Q_SHIFT;

  galr_pkg::mac_ctl_t c1, c2;
  logic signed [FEATURE_WIDTH-1:0]   a_masked;
  logic signed [PROD_W-1:0]          prod;
  logic signed [galr_pkg::VAL_W-1:0] bias_q;
  logic signed [ACC_W-1:0]           acc, acc_next, bias_ext;

  assign a_masked = c1.a_ok ? a_data : '0;
  assign bias_ext = ACC_W'(bias_q) <<< galr_pkg::Q_SHIFT;
  assign acc_next = (c2.first ? bias_ext : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1   <= '0;
      c2   <= '0;
      done <= 1'b0;
    end else begin
      c1 <= ctl;
      c2 <= c1;
      if (c2.valid && c2.last) begin
        done <= 1'b1;
      end else if (take) begin
        done <= 1'b0;
      end
    end
    if (c1.valid) begin
      prod <= w_data * a_masked;
      if (c1.first) begin
        bias_q <= b_data;
      end
    end
    if (c2.valid) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    if (acc[ACC_W-1] || acc == '0) begin
      res = '0;
    end else if (|acc[ACC_W-2:TOP_B]) begin
      res = '1;
    end else begin
      res = acc[TOP_B-1:galr_pkg::Q_SHIFT];
    end
  end

endmodule

[rtl/gnn_aggregate_linear_relu_unit.sv]
// Load, bias, clear and accumulate requests: one per cycle, done one cycle after acceptance.
// Compute request: n = active_dim rows (0 treated as 1, capped at min(MAX_DIM, 64)), each
// row streams n multiply-accumulates through the weight/aggregate memory read ports, then
// the MAC pipeline (c1, c2, done) drains before the result is registered out; input is held
// off for the whole run.
// Reset (synchronous, active high) clears control, aggregate valid bits and sets active_dim
// to 64; weight and bias memories are not cleared.
module gnn_aggregate_linear_relu_unit #(
  parameter int MAX_DIM       = 64,
  parameter int FEATURE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               active_dim_we,
  input  logic [galr_pkg::DIM_W-1:0]         active_dim,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         opcode,
  input  logic [galr_pkg::IDX_W-1:0]         row_index,
  input  logic [galr_pkg::IDX_W-1:0]         col_index,
  input  logic signed [galr_pkg::VAL_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [galr_pkg::IDX_W-1:0]         out_index,
  output logic [galr_pkg::OUT_W-1:0]         out_value,
  output logic                               last
);

  localparam int AW  = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
  localparam int WD  = MAX_DIM * MAX_DIM;
  localparam int WAW = WD > 1 ? $clog2(WD) : 1;
  localparam int LIM = MAX_DIM < 64 ? MAX_DIM : 64;
  localparam logic [galr_pkg::DIM_W-1:0] DIM_LIM = galr_pkg::DIM_W'(LIM);
  localparam logic [8:0] DIM9 = 9'(MAX_DIM);
  localparam logic signed [33:0] FHI = (34'sd1 <<< (FEATURE_WIDTH - 1)) - 34'sd1;
  localparam logic signed [33:0] FLO = -FHI - 34'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t state;

  logic [galr_pkg::DIM_W-1:0] dim_reg;
  logic [galr_pkg::DIM_W-1:0] dim_eff;
  logic [galr_pkg::DIM_W-1:0] n_q;
  logic [galr_pkg::IDX_W-1:0] ri, cj;
  logic [WAW-1:0]             base;

  logic                               s1_valid;
  galr_pkg::op_t                      s1_op;
  logic [galr_pkg::IDX_W-1:0]         s1_row, s1_col;
  logic signed [galr_pkg::VAL_W-1:0]  s1_val;

  logic                               row_ok, col_ok;
  logic [16:0]                        wa_full;

  logic                               agg_vld [MAX_DIM];
  logic                               fw_valid;
  logic [AW-1:0]                      fw_col;
  logic signed [FEATURE_WIDTH-1:0]    fw_data;
  logic signed [FEATURE_WIDTH-1:0]    agg_rdata, agg_old, agg_new;
  logic signed [33:0]                 agg_sum;

  logic                               w_we, b_we, a_we;
  logic [WAW-1:0]                     w_raddr;
  logic [AW-1:0]                      a_raddr;
  logic signed [galr_pkg::VAL_W-1:0]  w_rdata, b_rdata;

  galr_pkg::mac_ctl_t                 ctl;
  logic                               take, mac_done, out_free, col_last, row_last;
  logic [galr_pkg::OUT_W-1:0]         mac_res;

  // intake stage
  assign in_ready = (state == ST_IDLE) && !(s1_valid && s1_op == galr_pkg::OP_COMPUTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dim_reg  <= galr_pkg::DIM_CAP;
    end else begin
      s1_valid <= in_valid && in_ready;
      if (active_dim_we) begin
        dim_reg <= active_dim;
      end
    end
    if (in_valid && in_ready) begin
      s1_op  <= galr_pkg::op_t'(opcode);
      s1_row <= row_index;
      s1_col <= col_index;
      s1_val <= value;
    end
  end

  assign row_ok  = {3'b0, s1_row} < DIM9;
  assign col_ok  = {3'b0, s1_col} < DIM9;
  assign wa_full = 17'(s1_row) * 17'(MAX_DIM) + 17'(s1_col);

  assign w_we = s1_valid && s1_op == galr_pkg::OP_WEIGHT && row_ok && col_ok;
  assign b_we = s1_valid && s1_op == galr_pkg::OP_BIAS && row_ok;
  assign a_we = s1_valid && s1_op == galr_pkg::OP_ACCUM && col_ok;

  // read-modify-write of the aggregate, forwarding the previous write
  always_comb begin
    if (fw_valid && fw_col == AW'(s1_col)) begin
      agg_old = fw_data;
    end else if (agg_vld[AW'(s1_col)]) begin
      agg_old = agg_rdata;
    end else begin
      agg_old = '0;
    end
    agg_sum = 34'(agg_old) + 34'(s1_val);
    if (agg_sum > FHI) begin
      agg_new = FHI[FEATURE_WIDTH-1:0];
    end else if (agg_sum < FLO) begin
      agg_new = FLO[FEATURE_WIDTH-1:0];
    end else begin
      agg_new = agg_sum[FEATURE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
      for (int k = 0; k < MAX_DIM; k++) begin
        agg_vld[k] <= 1'b0;
      end
    end else if (s1_valid && s1_op == galr_pkg::OP_CLEAR) begin
      fw_valid <= 1'b0;
      for (int k = 0; k < MAX_DIM; k++) begin
        agg_vld[k] <= 1'b0;
      end
    end else if (a_we) begin
      fw_valid                <= 1'b1;
      agg_vld[AW'(s1_col)]    <= 1'b1;
    end
    if (a_we) begin
      fw_col  <= AW'(s1_col);
      fw_data <= agg_new;
    end
  end

  // memories
  assign w_raddr = base + WAW'(cj);
  assign a_raddr = (state == ST_IDLE) ? AW'(col_index) : AW'(cj);

  galr_ram #(.WIDTH(galr_pkg::VAL_W), .DEPTH(WD)) u_weight (
    .clk   (clk),
    .we    (w_we),
    .waddr (wa_full[WAW-1:0]),
    .wdata (s1_val),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  galr_ram #(.WIDTH(galr_pkg::VAL_W), .DEPTH(MAX_DIM)) u_bias (
    .clk   (clk),
    .we    (b_we),
    .waddr (AW'(s1_row)),
    .wdata (s1_val),
    .raddr (AW'(ri)),
    .rdata (b_rdata)
  );

  galr_ram #(.WIDTH(FEATURE_WIDTH), .DEPTH(MAX_DIM)) u_agg (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(s1_col)),
    .wdata (agg_new),
    .raddr (a_raddr),
    .rdata (agg_rdata)
  );

  // compute sequencer
  always_comb begin
    dim_eff = (dim_reg == '0) ? galr_pkg::DIM_W'(1) : dim_reg;
    if (dim_eff > DIM_LIM) begin
      dim_eff = DIM_LIM;
    end
  end

  assign col_last = {1'b0, cj} == n_q - galr_pkg::DIM_W'(1);
  assign row_last = {1'b0, ri} == n_q - galr_pkg::DIM_W'(1);
  assign out_free = !out_valid || out_ready;
  assign take     = (state == ST_DRAIN) && mac_done && out_free;

  assign ctl.valid = state == ST_RUN;
  assign ctl.first = cj == '0;
  assign ctl.last  = col_last;
  assign ctl.a_ok  = agg_vld[AW'(cj)];

  galr_mac #(.FEATURE_WIDTH(FEATURE_WIDTH)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .w_data (w_rdata),
    .a_data (agg_rdata),
    .b_data (b_rdata),
    .take   (take),
    .done   (mac_done),
    .res    (mac_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ri        <= '0;
      cj        <= '0;
      base      <= '0;
    end else begin
      if (out_valid && out_ready && !take) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s1_valid && s1_op == galr_pkg::OP_COMPUTE) begin
            state <= ST_RUN;
            n_q   <= dim_eff;
            ri    <= '0;
            cj    <= '0;
            base  <= '0;
          end
        end
        ST_RUN: begin
          cj <= cj + 1'b1;
          if (col_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (take) begin
            out_valid <= 1'b1;
            out_index <= ri;
            out_value <= mac_res;
            last      <= row_last;
            cj        <= '0;
            if (row_last) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_RUN;
              ri    <= ri + 1'b1;
              base  <= base + WAW'(MAX_DIM);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/galr_checker.sv]
module galr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [2:0]                         opcode,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [galr_pkg::IDX_W-1:0]         out_index,
  input logic [galr_pkg::OUT_W-1:0]         out_value,
  input logic                               last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_index) && $stable(out_value)
      && $stable(last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == galr_pkg::OP_COMPUTE |=> !in_ready)
    else $error("request taken right after compute");

  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("request taken during compute run");

endmodule

bind gnn_aggregate_linear_relu_unit galr_checker u_galr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_index (out_index),
  .out_value (out_value),
  .last      (last)
);
